>>> design/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg
// Shared types and codes for the byte ring FIFO with write and read
// transactions.
// ---------------------------------------------------------------------------
package brf_pkg;

   // Field widths fixed by the stream word layout.
   localparam int CMD_W   = 4;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 10;
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 56;

   // Command codes carried on the request side.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 4'd0,
      CMD_POP       = 4'd1,
      CMD_PEEK      = 4'd2,
      CMD_SKIP_TAIL = 4'd3,
      CMD_SKIP_HEAD = 4'd4,
      CMD_WR_BEGIN  = 4'd5,
      CMD_WR_END    = 4'd6,
      CMD_RD_RESV   = 4'd7,
      CMD_RD_END    = 4'd8,
      CMD_CLEAR     = 4'd9
   } cmd_type;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_SHORT = 2'd1,
      STAT_BUSY  = 2'd2,
      STAT_NONE  = 2'd3
   } status_type;

   // Control sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_REPLY,
      S_BURST
   } fsm_state_type;

endpackage

>>> design/byte_ring_fifo_with_rollback.sv
// Pointer, skip and transaction commands: results are registered in S_EXEC;
// a new word is taken in the cycle that result enters the output register.
// Pop and peek: bytes go from the single read port of the byte store through
// its read register to the output register, one byte per cycle unless the
// output stalls; up to MAX_BURST bytes per word. Reset: pointers and flags
// clear at once; a clearing pass zeroes the byte store, taking no request word.
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_rollback
// Ring byte FIFO with push, burst pop and peek, skips at both ends, and
// write and read transactions that commit or roll back.
// ---------------------------------------------------------------------------
module byte_ring_fifo_with_rollback #(
   parameter int BUFFER_SIZE = 1024,
   parameter int MAX_BURST   = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // data_byte[7:0], count[17:8], leave_count[27:18], commit_flag[28], zero pad
   input  logic [brf_pkg::REQ_W-1:0] req_tdata,
   // command[3:0]
   input  logic [brf_pkg::CMD_W-1:0] req_tuser,
   // push_block_end
   input  logic                      req_tlast,
   // Response stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_byte[7:0], status[9:8], done_count[19:10], start_index[29:20],
   // occupied[39:30], vacant[49:40], zero pad
   output logic [brf_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);
   import brf_pkg::*;

   localparam int PW = $clog2(BUFFER_SIZE);
   localparam int CW = (PW > CNT_W) ? PW : CNT_W;
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam logic [PW:0]   SIZE_X = (PW+1)'(BUFFER_SIZE);
   localparam logic [PW-1:0] LAST_P = PW'(BUFFER_SIZE - 1);

   // Distance from one ring position to another.
   function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] from_p,
                                               input logic [PW-1:0] to_p);
      logic [PW:0] diff;
      begin
         diff = {1'b0, to_p} - {1'b0, from_p};
         if (to_p < from_p) begin
            diff = diff + SIZE_X;
         end
         return PW'(diff);
      end
   endfunction

   // Sequencer.
   fsm_state_type state_ff, state_in;

   // Captured request word.
   cmd_type             cmd_ff, cmd_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic                blk_end_ff, blk_end_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    leave_ff, leave_in;
   logic                commit_ff, commit_in;

   // Ring pointers and transaction state.
   logic [PW-1:0]       head_ff, head_in;
   logic [PW-1:0]       tail_ff, tail_in;
   logic [PW-1:0]       wmark_ff, wmark_in;
   logic [PW-1:0]       rdend_ff, rdend_in;
   logic                wpend_ff, wpend_in;
   logic                rpend_ff, rpend_in;
   logic [CNT_W-1:0]    run_ff, run_in;

   // Result fields held for the reply.
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic [CNT_W-1:0]    res_done_ff, res_done_in;
   logic [CNT_W-1:0]    res_start_ff, res_start_in;

   // Burst read engine.
   logic [BW-1:0]       brst_n_ff, brst_n_in;
   logic [BW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic [BW-1:0]       emit_cnt_ff, emit_cnt_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [BYTE_W-1:0]   rd_data_ff;

   // Clearing pass.
   logic [PW-1:0]       clr_idx_ff, clr_idx_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Byte store.
   logic [BYTE_W-1:0]   mem [BUFFER_SIZE];
   logic                mem_we;
   logic [PW-1:0]       mem_waddr;
   logic [BYTE_W-1:0]   mem_wdata;
   logic                rd_en;

   // Shared datapath signals.
   logic [PW-1:0]       occ, vac;
   logic [CW-1:0]       req_amt, lim_amt, grant, occ_x, leave_x;
   logic                grant_short;
   logic [PW-1:0]       adv_base, adv_res;
   logic [PW:0]         adv_sum;
   logic [PW-1:0]       head_inc;
   logic [PW-1:0]       rd_ptr_inc;
   logic                wr_stale, rd_stale;
   logic                out_free, req_acc, emit, last_emit, burst_go, exec_on;

   // Occupancy from the current pointers.
   assign occ = ring_dist(tail_ff, head_ff);
   assign vac = LAST_P - occ;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign exec_on  = (state_ff == S_EXEC);

   // Request amount, saturated for bursts.
   assign occ_x   = CW'(occ);
   assign leave_x = CW'(leave_ff);
   always_comb begin
      req_amt = CW'(cnt_ff);
      if ((cmd_ff == CMD_POP || cmd_ff == CMD_PEEK) && cnt_ff > CNT_W'(MAX_BURST)) begin
         req_amt = CW'(MAX_BURST);
      end
   end

   // Limit set by the ring contents or free space.
   always_comb begin
      case (cmd_ff)
         CMD_POP: begin
            lim_amt = (occ_x <= leave_x) ? '0 : occ_x - leave_x;
         end
         CMD_SKIP_HEAD, CMD_WR_BEGIN: begin
            lim_amt = CW'(vac);
         end
         default: begin
            lim_amt = occ_x;
         end
      endcase
   end

   assign grant       = (lim_amt < req_amt) ? lim_amt : req_amt;
   assign grant_short = (grant < req_amt);

   // One shared ring advance for every pointer move by a granted amount.
   assign adv_base = (cmd_ff == CMD_SKIP_HEAD || cmd_ff == CMD_WR_BEGIN) ? head_ff : tail_ff;
   assign adv_sum  = {1'b0, adv_base} + (PW+1)'(grant);
   assign adv_res  = (adv_sum >= SIZE_X) ? PW'(adv_sum - SIZE_X) : PW'(adv_sum);

   assign head_inc   = (head_ff == LAST_P) ? '0 : head_ff + 1'b1;
   assign rd_ptr_inc = (rd_ptr_ff == LAST_P) ? '0 : rd_ptr_ff + 1'b1;

   // Stale end checks for rollback and read commit.
   assign wr_stale = ring_dist(wmark_ff, head_ff) > occ;
   assign rd_stale = ring_dist(tail_ff, rdend_ff) > occ;

   assign burst_go = ((cmd_ff == CMD_POP && !rpend_ff) || cmd_ff == CMD_PEEK) && (grant != '0);

   // Burst read and emit handshakes.
   assign rd_en     = (state_ff == S_BURST) && (rd_cnt_ff != brst_n_ff)
                      && (!rd_valid_ff || out_free);
   assign emit      = (state_ff == S_BURST) && rd_valid_ff && out_free;
   assign last_emit = emit && ((emit_cnt_ff + 1'b1) == brst_n_ff);

   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_REPLY) && out_free)
                       || last_emit;
   assign req_acc    = req_tvalid && req_tready;

   // Store write port: clearing pass or push.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = head_ff;
      mem_wdata = data_ff;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else if (exec_on && cmd_ff == CMD_PUSH && vac != '0) begin
         mem_we = 1'b1;
      end
   end

   // Byte store with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == LAST_P) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = burst_go ? S_BURST : S_REPLY;
         end
         S_REPLY: begin
            if (out_free) state_in = req_acc ? S_EXEC : S_IDLE;
         end
         S_BURST: begin
            if (last_emit) state_in = req_acc ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Request capture.
   always_comb begin
      cmd_in     = cmd_ff;
      data_in    = data_ff;
      blk_end_in = blk_end_ff;
      cnt_in     = cnt_ff;
      leave_in   = leave_ff;
      commit_in  = commit_ff;
      if (req_acc) begin
         cmd_in     = cmd_type'(req_tuser);
         data_in    = req_tdata[7:0];
         cnt_in     = req_tdata[17:8];
         leave_in   = req_tdata[27:18];
         commit_in  = req_tdata[28];
         blk_end_in = req_tlast;
      end
   end

   // Command execution: pointer updates and result fields.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      wmark_in      = wmark_ff;
      rdend_in      = rdend_ff;
      wpend_in      = wpend_ff;
      rpend_in      = rpend_ff;
      run_in        = run_ff;
      res_status_in = res_status_ff;
      res_done_in   = res_done_ff;
      res_start_in  = res_start_ff;
      brst_n_in     = brst_n_ff;
      rd_ptr_in     = rd_ptr_ff;
      if (exec_on) begin
         res_status_in = STAT_OK;
         res_done_in   = '0;
         res_start_in  = '0;
         brst_n_in     = BW'(grant);
         rd_ptr_in     = tail_ff;
         case (cmd_ff)
            CMD_PUSH: begin
               if (vac != '0) begin
                  head_in     = head_inc;
                  res_done_in = run_ff + 1'b1;
                  run_in      = blk_end_ff ? '0 : run_ff + 1'b1;
               end else begin
                  res_status_in = STAT_SHORT;
                  res_done_in   = run_ff;
                  run_in        = blk_end_ff ? '0 : run_ff;
               end
            end
            CMD_POP, CMD_PEEK: begin
               if (cmd_ff == CMD_POP && rpend_ff) begin
                  res_status_in = STAT_BUSY;
               end else begin
                  if (cmd_ff == CMD_POP) tail_in = adv_res;
                  if (grant == '0 || grant_short) res_status_in = STAT_SHORT;
               end
            end
            CMD_SKIP_TAIL: begin
               if (rpend_ff) begin
                  res_status_in = STAT_BUSY;
               end else begin
                  tail_in     = adv_res;
                  res_done_in = CNT_W'(grant);
                  if (grant_short) res_status_in = STAT_SHORT;
               end
            end
            CMD_SKIP_HEAD: begin
               head_in     = adv_res;
               res_done_in = CNT_W'(grant);
               if (grant_short) res_status_in = STAT_SHORT;
            end
            CMD_WR_BEGIN: begin
               if (wpend_ff) begin
                  res_status_in = STAT_BUSY;
               end else begin
                  wmark_in     = head_ff;
                  wpend_in     = 1'b1;
                  head_in      = adv_res;
                  res_done_in  = CNT_W'(grant);
                  res_start_in = CNT_W'(head_ff);
                  if (grant_short) res_status_in = STAT_SHORT;
               end
            end
            CMD_WR_END: begin
               if (!wpend_ff) begin
                  res_status_in = STAT_NONE;
               end else begin
                  if (!commit_ff) head_in = wr_stale ? tail_ff : wmark_ff;
                  wpend_in = 1'b0;
               end
            end
            CMD_RD_RESV: begin
               if (rpend_ff) begin
                  res_status_in = STAT_BUSY;
               end else begin
                  res_done_in  = CNT_W'(grant);
                  res_start_in = CNT_W'(tail_ff);
                  if (grant != '0) begin
                     rdend_in = adv_res;
                     rpend_in = 1'b1;
                  end
                  if (grant == '0 || grant_short) res_status_in = STAT_SHORT;
               end
            end
            CMD_RD_END: begin
               if (!rpend_ff) begin
                  res_status_in = STAT_NONE;
               end else begin
                  if (commit_ff) tail_in = rd_stale ? head_ff : rdend_ff;
                  rpend_in = 1'b0;
               end
            end
            CMD_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               wmark_in = '0;
               rdend_in = '0;
               wpend_in = 1'b0;
               rpend_in = 1'b0;
               run_in   = '0;
            end
            default: begin
               res_status_in = STAT_SHORT;
            end
         endcase
      end
   end

   // Burst counters and read data tracking.
   always_comb begin
      rd_cnt_in   = rd_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      rd_valid_in = rd_valid_ff;
      if (exec_on) begin
         rd_cnt_in   = '0;
         emit_cnt_in = '0;
      end
      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
      if (rd_en) begin
         rd_valid_in = 1'b1;
      end else if (emit) begin
         rd_valid_in = 1'b0;
      end
      if (emit) begin
         emit_cnt_in = emit_cnt_ff + 1'b1;
      end
   end

   // Clearing pass counter.
   assign clr_idx_in = (state_ff == S_CLEAR) ? clr_idx_ff + 1'b1 : clr_idx_ff;

   // Output register load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_REPLY && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_data_in  = {6'b0, CNT_W'(vac), CNT_W'(occ), res_start_ff, res_done_ff,
                         res_status_ff, 8'b0};
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = last_emit;
         rsp_data_in  = {6'b0, CNT_W'(vac), CNT_W'(occ), 10'b0,
                         CNT_W'(emit_cnt_ff + 1'b1), res_status_ff, rd_data_ff};
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wmark_ff     <= '0;
         rdend_ff     <= '0;
         wpend_ff     <= 1'b0;
         rpend_ff     <= 1'b0;
         run_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         emit_cnt_ff  <= '0;
         brst_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wmark_ff     <= wmark_in;
         rdend_ff     <= rdend_in;
         wpend_ff     <= wpend_in;
         rpend_ff     <= rpend_in;
         run_ff       <= run_in;
         rd_valid_ff  <= rd_valid_in;
         rd_cnt_ff    <= rd_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         brst_n_ff    <= brst_n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      data_ff       <= data_in;
      blk_end_ff    <= blk_end_in;
      cnt_ff        <= cnt_in;
      leave_ff      <= leave_in;
      commit_ff     <= commit_in;
      res_status_ff <= res_status_in;
      res_done_ff   <= res_done_in;
      res_start_ff  <= res_start_in;
      rd_ptr_ff     <= rd_en ? rd_ptr_inc : rd_ptr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Pointers always stay inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < SIZE_X) && ({1'b0, tail_ff} < SIZE_X))
      else $error("ring pointer out of range");

   // At most one read byte is in flight between the store and the output.
   a_burst_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BURST) |-> (rd_cnt_ff - emit_cnt_ff) == BW'(rd_valid_ff))
      else $error("burst read and emit counts disagree");

   // An open read reservation always spans at least one byte.
   a_resv_span: assert property (@(posedge clock) disable iff (reset)
      rpend_ff |-> (rdend_ff != tail_ff))
      else $error("empty read reservation held open");

endmodule
